>>> src/afg_pkg.sv
// afg_pkg: shared constants, types and the skip pattern table of the frameskip governor.
// No dependencies.
`default_nettype none
package afg_pkg;

  localparam int SKIP_LEVELS   = 12;
  localparam int TIME_BITS_DEF = 64;
  localparam int QUOT_W        = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 20;

  localparam logic [CFG_IDX_W-1:0] REG_AUTO_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VSYNC_FLIP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH     = 3'd5;

  localparam logic [3:0]  MAX_LEVEL     = 4'(SKIP_LEVELS - 1);
  localparam logic [4:0]  FSS_MAX       = 5'd31;
  localparam logic [4:0]  FSS_SETTLED   = 5'(2 * SKIP_LEVELS);
  localparam logic [15:0] SAT16         = 16'hFFFF;
  localparam logic [15:0] SPEED_RESET   = 16'd100;
  localparam logic [15:0] FPS_RESET     = 16'd60;
  localparam logic [15:0] SPEED_FULL    = 16'd99;
  localparam logic [15:0] SPEED_LOW     = 16'd80;
  localparam logic [6:0]  SPEED_MID     = 7'd90;
  localparam logic [7:0]  RECIP5        = 8'd205;
  localparam logic [26:0] SPEED_SCALE   = 27'd100000000;
  localparam logic [19:0] FPS_SCALE     = 20'd1000000;
  localparam logic [19:0] PERIOD_RESET  = 20'd16667;
  localparam logic [9:0]  REFRESH_RESET = 10'd60;
  localparam logic [6:0]  VSYNC_MARGIN  = 7'd100;
  localparam logic signed [5:0] ACC_UP  = 6'sd3;
  localparam logic signed [5:0] ACC_LOW = -6'sd2;

  typedef enum logic [3:0] {
    S_IDLE, S_WARM, S_BASE, S_TGT, S_PACE, S_ELAP, S_CHK,
    S_Q1, S_W1, S_Q2, S_W2, S_Q3, S_W3, S_ADJ, S_LOOP, S_OUT
  } afg_state_t;

  typedef struct packed {
    logic              start;
    logic [QUOT_W-1:0] dividend;
  } div_req_t;

  function automatic logic [SKIP_LEVELS-1:0] pat_row(input logic [3:0] level);
    logic [SKIP_LEVELS-1:0] row;
    case (level)
      4'd0:    row = 12'h000;
      4'd1:    row = 12'h800;
      4'd2:    row = 12'h820;
      4'd3:    row = 12'h888;
      4'd4:    row = 12'h924;
      4'd5:    row = 12'hA52;
      4'd6:    row = 12'hAAA;
      4'd7:    row = 12'hB5A;
      4'd8:    row = 12'hDB6;
      4'd9:    row = 12'hEEE;
      4'd10:   row = 12'hFBE;
      4'd11:   row = 12'hFFE;
      default: row = 12'h000;
    endcase
    return row;
  endfunction

endpackage
`default_nettype wire

>>> src/afg_div.sv
// afg_div: restoring divider, one quotient bit per cycle, 32-bit dividend.
// Depends on afg_pkg.
`default_nettype none
module afg_div #(
  parameter int TIME_BITS = afg_pkg::TIME_BITS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  afg_pkg::div_req_t              req,
  input  wire  [TIME_BITS-1:0]           divisor,
  output logic [afg_pkg::QUOT_W-1:0]     quotient,
  output logic                           done
);
  import afg_pkg::*;

  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [TIME_BITS-1:0] dsr_r;
  logic [QUOT_W-1:0]    dq_r, dq_nxt;
  logic [5:0]           cnt_r;
  logic                 busy_r, done_r;
  logic [TIME_BITS:0]   trial;
  logic                 fits;

  always_comb begin
    trial   = {rem_r, dq_r[QUOT_W-1]};
    fits    = trial >= {1'b0, dsr_r};
    rem_nxt = fits ? TIME_BITS'(trial - {1'b0, dsr_r}) : trial[TIME_BITS-1:0];
    dq_nxt  = {dq_r[QUOT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dq_r  <= req.dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign quotient = dq_r;
  assign done     = done_r;

  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < dsr_r) else $error("remainder not below divisor");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("start while busy");

endmodule
`default_nettype wire

>>> src/auto_frameskip_governor_top.sv
// auto_frameskip_governor_top: frame pacing with a 12-level automatic frameskip.
// Depends on afg_pkg and afg_div.
//
// Usage: one input transfer per frame end carries in_now_us, a free-running
// microsecond time. Each input transfer yields exactly one output transfer:
// skip flag, wait before presenting, vsync-flip flag, window flag, last
// measured speed percent and fps, and the skip level after the frame.
// Settings are written on cfg_we/cfg_index/cfg_wdata while the block is idle.
// Frames that are skipped or of a nonzero phase pass only through the warm, base,
// target, pace and output states. A rendered phase-0 frame measures the window
// with up to three serial divisions on the shared one-bit-per-cycle divider,
// followed by level stepping. One frame is worked on at a time; in_stall
// stays high from the input transfer until the result is in the output register.
// The output register holds its result while out_stall is high; the next
// frame is then taken but waits for the register to drain before finishing.
// Reset (synchronous, rst_n low) restores all settings and the window state;
// the first frame after reset loads the skip level.
`default_nettype none
module auto_frameskip_governor_top #(
  parameter int TIME_BITS = afg_pkg::TIME_BITS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [63:0]                        in_now_us,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_skip_frame,
  output logic [63:0]                        out_wait_us,
  output logic                               out_flip_on_vsync,
  output logic                               out_window_done,
  output logic [15:0]                        out_speed_percent,
  output logic [15:0]                        out_rendered_fps,
  output logic [3:0]                         out_level_now,
  input  wire                                cfg_we,
  input  wire  [afg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [afg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import afg_pkg::*;

  afg_state_t state_r, state_nxt;

  logic        auto_r, spdlim_r, vflip_r;
  logic [3:0]  fixlvl_r;
  logic [19:0] period_r;
  logic [9:0]  refresh_r;

  logic [TIME_BITS-1:0] now_r, ws_r, base_r, tgt_r, curr_r, elap_r, wait_r;
  logic [3:0]  lvl_r, phase_r;
  logic signed [5:0] acc_r;
  logic        warm_r, skip_r, flip_r, done_r;
  logic [4:0]  fiw_r, riw_r, fss_r;
  logic [15:0] spd_r, fps_r;
  logic [QUOT_W-1:0] q1_r;

  logic [TIME_BITS-1:0] span, divisor;
  logic [23:0] phase_off;
  logic [6:0]  below_mid;
  logic [4:0]  acc_step;
  logic        accept, out_free, adj_on;
  div_req_t    div_req;
  logic [QUOT_W-1:0] quot;
  logic        div_done;
  logic [15:0] quot_sat;
  logic [SKIP_LEVELS-1:0] pat_bits;

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign span      = TIME_BITS'(24'(period_r) * 24'd12);
  assign phase_off = 24'(phase_r) * 24'(period_r);
  assign below_mid = SPEED_MID - spd_r[6:0];
  assign acc_step  = 5'((15'(below_mid) * 15'(RECIP5)) >> 10);
  assign adj_on    = auto_r && spdlim_r && (fss_r > FSS_SETTLED);
  assign quot_sat  = (|quot[QUOT_W-1:16]) ? SAT16 : quot[15:0];
  assign pat_bits  = pat_row(lvl_r);

  afg_div #(.TIME_BITS(TIME_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .divisor  (divisor),
    .quotient (quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r    <= 1'b0;
      fixlvl_r  <= '0;
      spdlim_r  <= 1'b1;
      vflip_r   <= 1'b0;
      period_r  <= PERIOD_RESET;
      refresh_r <= REFRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AUTO_MODE:   auto_r    <= cfg_wdata[0];
        REG_FIXED_LEVEL: fixlvl_r  <= cfg_wdata[3:0];
        REG_SPEED_LIMIT: spdlim_r  <= cfg_wdata[0];
        REG_VSYNC_FLIP:  vflip_r   <= cfg_wdata[0];
        REG_PERIOD:      period_r  <= cfg_wdata[19:0];
        REG_REFRESH:     refresh_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_WARM;
      S_WARM:  state_nxt = S_BASE;
      S_BASE:  state_nxt = S_TGT;
      S_TGT:   state_nxt = S_PACE;
      S_PACE:  state_nxt = (skip_r || phase_r != 4'd0) ? S_OUT : S_ELAP;
      S_ELAP:  state_nxt = S_CHK;
      S_CHK:   state_nxt = (elap_r == '0) ? S_ADJ : S_Q1;
      S_Q1:    state_nxt = S_W1;
      S_W1:    if (div_done) state_nxt = S_Q2;
      S_Q2:    state_nxt = (refresh_r == '0) ? S_Q3 : S_W2;
      S_W2:    if (div_done) state_nxt = S_Q3;
      S_Q3:    state_nxt = S_W3;
      S_W3:    if (div_done) state_nxt = S_ADJ;
      S_ADJ:   state_nxt = S_LOOP;
      S_LOOP:  if (acc_r > ACC_LOW) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != S_IDLE);
    div_req  = '0;
    divisor  = elap_r;
    case (state_r)
      S_Q1: begin
        div_req.start    = 1'b1;
        div_req.dividend = 32'(fiw_r) * 32'(SPEED_SCALE);
      end
      S_Q2: begin
        div_req.start    = (refresh_r != '0);
        div_req.dividend = q1_r;
        divisor          = TIME_BITS'(refresh_r);
      end
      S_Q3: begin
        div_req.start    = 1'b1;
        div_req.dividend = 32'(25'(riw_r) * 25'(FPS_SCALE));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lvl_r   <= '0;
      acc_r   <= '0;
      phase_r <= '0;
      ws_r    <= '0;
      base_r  <= '0;
      warm_r  <= 1'b1;
      fiw_r   <= '0;
      riw_r   <= '0;
      fss_r   <= '0;
      spd_r   <= SPEED_RESET;
      fps_r   <= FPS_RESET;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && !out_stall && state_r != S_OUT) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: if (accept) now_r <= in_now_us[TIME_BITS-1:0];
        S_WARM: begin
          if (warm_r) begin
            lvl_r  <= auto_r ? 4'd0 : ((fixlvl_r > MAX_LEVEL) ? MAX_LEVEL : fixlvl_r);
            ws_r   <= now_r - span;
            warm_r <= 1'b0;
          end
        end
        S_BASE: begin
          skip_r <= pat_bits[phase_r];
          if (phase_r == 4'd0) base_r <= ws_r + span;
          if (fss_r < FSS_MAX) fss_r <= fss_r + 5'd1;
          fiw_r  <= fiw_r + 5'd1;
          wait_r <= '0;
          flip_r <= 1'b0;
          done_r <= 1'b0;
          curr_r <= now_r;
        end
        S_TGT: tgt_r <= base_r + TIME_BITS'(phase_off);
        S_PACE: begin
          if (!skip_r) begin
            riw_r <= riw_r + 5'd1;
            if (spdlim_r && tgt_r > now_r) begin
              wait_r <= tgt_r - now_r;
              curr_r <= tgt_r;
              flip_r <= vflip_r && (tgt_r - now_r > TIME_BITS'(VSYNC_MARGIN));
            end
          end
        end
        S_ELAP: begin
          elap_r <= curr_r - ws_r;
          done_r <= 1'b1;
        end
        S_CHK: begin
          if (elap_r == '0) begin
            spd_r <= SAT16;
            fps_r <= SAT16;
          end
        end
        S_W1: if (div_done) q1_r <= quot;
        S_Q2: if (refresh_r == '0) spd_r <= SAT16;
        S_W2: if (div_done) spd_r <= quot_sat;
        S_W3: if (div_done) fps_r <= quot_sat;
        S_ADJ: begin
          ws_r  <= curr_r;
          fiw_r <= '0;
          riw_r <= '0;
          if (adj_on) begin
            if (spd_r >= SPEED_FULL) begin
              if (acc_r + 6'sd1 >= ACC_UP) begin
                acc_r <= '0;
                if (lvl_r != 4'd0) lvl_r <= lvl_r - 4'd1;
              end else begin
                acc_r <= acc_r + 6'sd1;
              end
            end else if (spd_r < SPEED_LOW) begin
              acc_r <= acc_r - $signed({1'b0, acc_step});
            end else if (lvl_r < 4'd8) begin
              acc_r <= acc_r - 6'sd1;
            end
          end
        end
        S_LOOP: begin
          if (acc_r <= ACC_LOW) begin
            acc_r <= acc_r + 6'sd2;
            if (lvl_r < MAX_LEVEL) lvl_r <= lvl_r + 4'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid         <= 1'b1;
            out_skip_frame    <= skip_r;
            out_wait_us       <= 64'(wait_r);
            out_flip_on_vsync <= flip_r;
            out_window_done   <= done_r;
            out_speed_percent <= spd_r;
            out_rendered_fps  <= fps_r;
            out_level_now     <= lvl_r;
            phase_r <= (phase_r == MAX_LEVEL) ? 4'd0 : phase_r + 4'd1;
          end
        end
        default: ;
      endcase
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    lvl_r <= MAX_LEVEL && phase_r <= MAX_LEVEL) else $error("level or phase out of range");
  a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> (acc_r > ACC_LOW && acc_r < ACC_UP)) else $error("accumulator range");
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_skip_frame |-> out_wait_us == 64'd0 && !out_flip_on_vsync
      && !out_window_done) else $error("skipped frame carries pacing");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_WARM) else $error("accepted frame not started");

endmodule
`default_nettype wire

>>> sim/afg_checker.sv
// afg_checker: watches the frame, result and settings ports of the frameskip governor,
// predicts each result and compares it field by field. Depends on afg_pkg.
`default_nettype none
module afg_checker (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  input  wire                             in_stall,
  input  wire  [63:0]                     in_now_us,
  input  wire                             out_valid,
  input  wire                             out_stall,
  input  wire                             out_skip_frame,
  input  wire  [63:0]                     out_wait_us,
  input  wire                             out_flip_on_vsync,
  input  wire                             out_window_done,
  input  wire  [15:0]                     out_speed_percent,
  input  wire  [15:0]                     out_rendered_fps,
  input  wire  [3:0]                      out_level_now,
  input  wire                             cfg_we,
  input  wire  [afg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [afg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              mismatches,
  output int                              pending
);
  import afg_pkg::*;

  typedef struct {
    logic        skip;
    logic [63:0] wait_us;
    logic        flip;
    logic        done;
    logic [15:0] speed;
    logic [15:0] fps;
    logic [3:0]  level;
  } frame_verdict_t;

  localparam logic [0:11] SKIP_MAP [SKIP_LEVELS] = '{
    12'b000000000000, 12'b000000000001, 12'b000001000001, 12'b000100010001,
    12'b001001001001, 12'b010010100101, 12'b010101010101, 12'b010110101101,
    12'b011011011011, 12'b011101110111, 12'b011111011111, 12'b011111111111
  };

  frame_verdict_t verdicts[$];

  logic        auto_on, limit_on, vsync_on;
  logic [3:0]  fixed_lvl;
  logic [19:0] period;
  logic [9:0]  refresh;

  logic [3:0]  level;
  int          acc;
  int          phase;
  logic [63:0] win_start, win_base;
  logic        warming;
  int          frames_win, rendered_win, frames_total;
  logic [15:0] speed, fps;

  function automatic logic [15:0] clip16(input logic [63:0] v);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic frame_verdict_t pace_frame(input logic [63:0] now);
    frame_verdict_t r;
    logic [63:0] span, curr, target, elapsed, q;
    span = 64'd12 * period;
    r = '{default: '0};
    if (warming) begin
      level = auto_on ? 4'd0 : ((fixed_lvl > 4'd11) ? 4'd11 : fixed_lvl);
      win_start = now - span;
      warming = 1'b0;
    end
    r.skip = SKIP_MAP[level][phase];
    if (phase == 0) win_base = win_start + span;
    if (frames_total < 31) frames_total++;
    frames_win = (frames_win + 1) & 31;
    if (!r.skip) begin
      curr = now;
      if (limit_on) begin
        target = win_base + 64'(phase) * period;
        if (vsync_on && target > curr && target - curr > 64'd100) r.flip = 1'b1;
        if (target > curr) begin
          r.wait_us = target - curr;
          curr = target;
        end
      end
      rendered_win = (rendered_win + 1) & 31;
      if (phase == 0) begin
        elapsed = curr - win_start;
        r.done = 1'b1;
        if (elapsed == 0) begin
          speed = 16'hFFFF;
          fps = 16'hFFFF;
        end else begin
          q = (64'(frames_win) * 64'd100000000) / elapsed;
          speed = (refresh == 0) ? 16'hFFFF : clip16(q / refresh);
          fps = clip16((64'(rendered_win) * 64'd1000000) / elapsed);
        end
        win_start = curr;
        frames_win = 0;
        rendered_win = 0;
        if (auto_on && limit_on && frames_total > 24) begin
          if (speed >= 16'd99) begin
            acc++;
            if (acc >= 3) begin
              acc = 0;
              if (level > 0) level--;
            end
          end else begin
            if (speed < 16'd80) acc -= (90 - int'(speed)) / 5;
            else if (level < 8) acc--;
            while (acc <= -2) begin
              acc += 2;
              if (level < 4'd11) level++;
            end
          end
        end
      end
    end
    phase = (phase + 1) % SKIP_LEVELS;
    r.speed = speed;
    r.fps = fps;
    r.level = level;
    return r;
  endfunction

  always @(posedge clk) begin
    frame_verdict_t e;
    if (!rst_n) begin
      auto_on <= 1'b0; fixed_lvl <= 4'd0; limit_on <= 1'b1; vsync_on <= 1'b0;
      period <= 20'd16667; refresh <= 10'd60;
      level = 4'd0; acc = 0; phase = 0; win_start = '0; win_base = '0;
      warming = 1'b1; frames_win = 0; rendered_win = 0; frames_total = 0;
      speed = 16'd100; fps = 16'd60;
      verdicts.delete();
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AUTO_MODE:   auto_on <= cfg_wdata[0];
          REG_FIXED_LEVEL: fixed_lvl <= cfg_wdata[3:0];
          REG_SPEED_LIMIT: limit_on <= cfg_wdata[0];
          REG_VSYNC_FLIP:  vsync_on <= cfg_wdata[0];
          REG_PERIOD:      period <= cfg_wdata[19:0];
          REG_REFRESH:     refresh <= cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) verdicts.push_back(pace_frame(in_now_us));
      if (out_valid && !out_stall) begin
        if (verdicts.size() == 0) begin
          $error("unexpected result transfer");
          mismatches <= mismatches + 1;
        end else begin
          e = verdicts.pop_front();
          if (out_skip_frame !== e.skip || out_wait_us !== e.wait_us ||
              out_flip_on_vsync !== e.flip || out_window_done !== e.done ||
              out_speed_percent !== e.speed || out_rendered_fps !== e.fps ||
              out_level_now !== e.level)
            mismatches <= mismatches + 1;
          if (out_skip_frame !== e.skip)
            $error("skip_frame: expected %0d, got %0d", e.skip, out_skip_frame);
          if (out_wait_us !== e.wait_us)
            $error("wait_us: expected %0d, got %0d", e.wait_us, out_wait_us);
          if (out_flip_on_vsync !== e.flip)
            $error("flip_on_vsync: expected %0d, got %0d", e.flip, out_flip_on_vsync);
          if (out_window_done !== e.done)
            $error("window_done: expected %0d, got %0d", e.done, out_window_done);
          if (out_speed_percent !== e.speed)
            $error("speed_percent: expected %0d, got %0d", e.speed, out_speed_percent);
          if (out_rendered_fps !== e.fps)
            $error("rendered_fps: expected %0d, got %0d", e.fps, out_rendered_fps);
          if (out_level_now !== e.level)
            $error("level_now: expected %0d, got %0d", e.level, out_level_now);
        end
      end
      pending <= verdicts.size();
    end
  end

endmodule
`default_nettype wire

>>> sim/tb.sv
// tb: drives frame ends and settings into auto_frameskip_governor_top with random
// gaps and output stalls, and gives the verdict. Depends on afg_pkg, afg_checker and the top.
`default_nettype none
module tb;
  import afg_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_now_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_skip_frame, out_flip_on_vsync, out_window_done;
  logic [63:0] out_wait_us;
  logic [15:0] out_speed_percent, out_rendered_fps;
  logic [3:0]  out_level_now;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int          mismatches, pending;

  logic [63:0] clock_us;
  logic [19:0] cur_period;
  int          frames_sent, burst_left, gappy;
  int          stall_mode = 0;
  int          cyc = 0;
  int          quiet = 0;

  always #5 clk = ~clk;

  auto_frameskip_governor_top u_top (.*);
  afg_checker u_chk (.*);

  always @(negedge clk) begin
    cyc <= cyc + 1;
    if (cyc % 256 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= (cyc[5:3] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 6000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
  endtask

  task automatic drain;
    cfg_we = 1'b0;
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic send_frame(input logic [63:0] t);
    if (gappy != 0 && burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
      burst_left = $urandom_range(1, 10);
    end
    burst_left = (burst_left > 0) ? burst_left - 1 : 0;
    in_valid = 1'b1;
    in_now_us = t;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    frames_sent++;
  endtask

  task automatic run_frames(input int n);
    logic [63:0] delta;
    int          pct;
    pct = $urandom_range(60, 200);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: begin
          clock_us = {$urandom, $urandom};
          delta = '0;
        end
        1:       delta = 64'($urandom_range(0, 3));
        2:       delta = {$urandom, $urandom};
        default: delta = (64'(cur_period) * pct) / 100 + 64'($urandom_range(0, 200));
      endcase
      clock_us = clock_us + delta;
      send_frame(clock_us);
    end
  endtask

  initial begin
    clock_us = 64'd5000000;
    cur_period = 20'd16667;
    frames_sent = 0;
    burst_left = 0;
    gappy = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // fixed level beyond the table, early frames for vsync flips
    set_reg(REG_FIXED_LEVEL, 20'd15);
    set_reg(REG_VSYNC_FLIP, 20'd1);
    cfg_we = 1'b0;
    for (int i = 0; i < 13; i++) send_frame(clock_us + 64'(i) * 1000);
    drain();

    // no pacing, frozen time across the wrap point, zero refresh rate
    set_reg(REG_SPEED_LIMIT, 20'd0);
    set_reg(REG_REFRESH, 20'd0);
    set_reg(REG_PERIOD, 20'd1000000);
    set_reg(REG_AUTO_MODE, 20'd1);
    cfg_we = 1'b0;
    for (int i = 0; i < 24; i++) send_frame(64'hFFFF_FFFF_FFFF_FFF0);
    drain();

    clock_us = 64'hFFFF_FFFF_FF00_0000;
    while (frames_sent < 650) begin
      set_reg(REG_AUTO_MODE, 20'($urandom_range(0, 3) != 0));
      set_reg(REG_FIXED_LEVEL, 20'($urandom_range(0, 15)));
      set_reg(REG_SPEED_LIMIT, 20'($urandom_range(0, 4) != 0));
      set_reg(REG_VSYNC_FLIP, 20'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0:       cur_period = 20'd1;
        1:       cur_period = 20'd1000000;
        2:       cur_period = 20'hFFFFF;
        default: cur_period = 20'($urandom_range(1000, 40000));
      endcase
      set_reg(REG_PERIOD, cur_period);
      case ($urandom_range(0, 5))
        0:       set_reg(REG_REFRESH, 20'd1);
        1:       set_reg(REG_REFRESH, 20'd1000);
        2:       set_reg(REG_REFRESH, 20'h3FF);
        default: set_reg(REG_REFRESH, 20'($urandom_range(30, 144)));
      endcase
      cfg_we = 1'b0;
      gappy = $urandom_range(0, 2);
      run_frames($urandom_range(40, 90));
      drain();
    end

    if (mismatches == 0 && pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
src/afg_pkg.sv
src/afg_div.sv
src/auto_frameskip_governor_top.sv
sim/afg_checker.sv
sim/tb.sv
